// File: rtl/tms_pkg.sv
package tms_pkg;

    localparam int NUM_SUBJECTS   = 1024;
    localparam int NUM_PREDICATES = 64;
    localparam int SLOTS_PER_PAIR = 4;

    localparam int SUBJ_W = 10;
    localparam int PRED_W = 6;
    localparam int OBJ_W  = 10;

    localparam logic OP_ASK = 1'b0;
    localparam logic OP_ADD = 1'b1;

    // one entry per (predicate, subject) pair
    localparam int PAIRS  = NUM_PREDICATES * NUM_SUBJECTS;
    localparam int PAIR_W = $clog2(PAIRS);

    localparam int CNT_W = $clog2(SLOTS_PER_PAIR + 1);
    localparam int SEL_W = (SLOTS_PER_PAIR > 1) ? $clog2(SLOTS_PER_PAIR) : 1;
    localparam int SLOT_WORD_W = SLOTS_PER_PAIR * OBJ_W;

    // count memory packs several pair counts into one row
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROWS       = PAIRS / LANES;
    localparam int ROW_AW     = PAIR_W - LANE_W;
    localparam int CROW_W     = LANES * CNT_W;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [CNT_W-1:0] wr_cnt;
    } cnt_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
    } cnt_stat_t;

endpackage

// File: rtl/tms_count_mem.sv
module tms_count_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tms_pkg::cnt_req_t          req,
    input  logic [tms_pkg::PAIR_W-1:0] pair,
    output tms_pkg::cnt_stat_t         stat
);
    import tms_pkg::*;

    logic [CROW_W-1:0] cnt_mem [ROWS];
    logic [CROW_W-1:0] row_reg;
    logic [CROW_W-1:0] row_wr;
    logic              clr_busy_reg;
    logic [ROW_AW-1:0] clr_addr_reg;
    logic [ROW_AW-1:0] row_addr;
    logic [LANE_W-1:0] lane;

    assign row_addr = pair[PAIR_W-1:LANE_W];
    assign lane     = pair[LANE_W-1:0];

    always_comb
    begin
        row_wr = row_reg;
        row_wr[lane*CNT_W +: CNT_W] = req.wr_cnt;
    end

    // sweep zeros through every row after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ROW_AW'(ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            cnt_mem[clr_addr_reg] <= '0;
        end
        else if (req.wr)
        begin
            cnt_mem[row_addr] <= row_wr;
        end
        if (req.rd)
        begin
            row_reg <= cnt_mem[row_addr];
        end
    end

    assign stat.busy = clr_busy_reg;
    assign stat.cnt  = row_reg[lane*CNT_W +: CNT_W];

endmodule

// File: rtl/triple_membership_store.sv
// Triple membership store. Each item is an add or an ask of a (subject,
// predicate, object) triple and gives one result: hit when the triple was
// already present, full_res when an add found all of the pair's object slots
// in use and was dropped. An item passes from transfer to the next free
// input through a read of the pair's count and slot word, then one slot
// compare per cycle on a single comparator until a match or the end of the
// used slots, then a write-back, which also waits while the previous result
// is still unaccepted at the output. The subject bit of a predicate is not
// kept apart: it is set exactly when the pair's count is nonzero. After
// reset the count memory is swept clean, one row of eight counts per cycle;
// in_ready stays low meanwhile.
module triple_membership_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [tms_pkg::SUBJ_W-1:0] subject,
    input  logic [tms_pkg::PRED_W-1:0] predicate,
    input  logic [tms_pkg::OBJ_W-1:0]  object_id,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic                       full_res
);
    import tms_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic                   op_reg;
    logic [PAIR_W-1:0]      pair_reg;
    logic [OBJ_W-1:0]       obj_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_next;
    logic                   match_reg;
    logic                   match_next;
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic                   full_reg;
    logic [SLOT_WORD_W-1:0] slot_reg;
    logic [SLOT_WORD_W-1:0] slot_wr;
    logic [SLOT_WORD_W-1:0] slot_mem [PAIRS];
    logic                   slot_we;
    logic [OBJ_W-1:0]       slot_cur;
    logic                   pair_full;
    logic                   do_store;
    logic                   finish;
    cnt_req_t               cnt_req;
    cnt_stat_t              cnt_stat;

    tms_count_mem u_count (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .pair  (pair_reg),
        .stat  (cnt_stat)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !cnt_stat.busy;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign full_res  = full_reg;

    assign slot_cur  = slot_reg[idx_reg[SEL_W-1:0]*OBJ_W +: OBJ_W];
    assign pair_full = cnt_stat.cnt >= CNT_W'(SLOTS_PER_PAIR);
    assign finish    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign do_store  = (op_reg == OP_ADD) && !match_reg && !pair_full;
    assign slot_we   = finish && do_store;

    always_comb
    begin
        slot_wr = slot_reg;
        slot_wr[cnt_stat.cnt[SEL_W-1:0]*OBJ_W +: OBJ_W] = obj_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        match_next     = match_reg;
        cnt_req.rd     = 1'b0;
        cnt_req.wr     = slot_we;
        cnt_req.wr_cnt = cnt_stat.cnt + 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_req.rd = 1'b1;
                idx_next   = '0;
                match_next = 1'b0;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // walk the used slots one per cycle
                priority if (idx_reg >= cnt_stat.cnt)
                begin
                    state_next = ST_DONE;
                end
                else if (slot_cur == obj_reg)
                begin
                    match_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        match_reg <= match_next;
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            pair_reg <= {predicate, subject};
            obj_reg  <= object_id;
        end
        if (finish)
        begin
            hit_reg  <= match_reg;
            full_reg <= (op_reg == OP_ADD) && !match_reg && pair_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[pair_reg] <= slot_wr;
        end
        if (state_reg == ST_READ)
        begin
            slot_reg <= slot_mem[pair_reg];
        end
    end

`ifndef SYNTH
    a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && full_res))
        else $error("hit and full_res both set");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_stat.busy |-> !in_ready)
        else $error("input ready during clearing sweep");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (idx_reg <= CNT_W'(SLOTS_PER_PAIR)))
        else $error("slot index past last slot");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside write-back");

    a_no_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> !cnt_stat.busy)
        else $error("slot write during clearing sweep");
`endif

endmodule

// File: tb/triple_membership_store_tb.sv
module triple_membership_store_tb;

    import tms_pkg::*;

    typedef struct packed {
        logic hit;
        logic full_res;
    } triple_answer_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              operation = OP_ASK;
    logic [SUBJ_W-1:0] subject   = '0;
    logic [PRED_W-1:0] predicate = '0;
    logic [OBJ_W-1:0]  object_id = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit;
    logic              full_res;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;

    // shadow copy of the store
    bit               subject_marked [NUM_PREDICATES][NUM_SUBJECTS];
    int unsigned      slots_used     [NUM_PREDICATES][NUM_SUBJECTS];
    logic [OBJ_W-1:0] slot_object    [NUM_PREDICATES][NUM_SUBJECTS][SLOTS_PER_PAIR];

    triple_answer_t pending_answers[$];

    triple_membership_store i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .subject   (subject),
        .predicate (predicate),
        .object_id (object_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .full_res  (full_res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic triple_answer_t apply_triple(logic op, logic [SUBJ_W-1:0] s,
                                                    logic [PRED_W-1:0] p,
                                                    logic [OBJ_W-1:0] o);
        triple_answer_t ans;
        bit             present;
        ans = '0;
        present = 1'b0;
        if (s < NUM_SUBJECTS && p < NUM_PREDICATES)
        begin
            for (int k = 0; k < SLOTS_PER_PAIR; k++)
                if (k < slots_used[p][s] && slot_object[p][s][k] == o)
                    present = 1'b1;
            if (op == OP_ASK)
            begin
                ans.hit = subject_marked[p][s] && present;
            end
            else
            begin
                subject_marked[p][s] = 1'b1;
                if (present)
                    ans.hit = 1'b1;
                else if (slots_used[p][s] >= SLOTS_PER_PAIR)
                    ans.full_res = 1'b1;
                else
                begin
                    slot_object[p][s][SEL_W'(slots_used[p][s])] = o;
                    slots_used[p][s]++;
                end
            end
        end
        return ans;
    endfunction

    task automatic send_triple(logic op, logic [SUBJ_W-1:0] s, logic [PRED_W-1:0] p,
                               logic [OBJ_W-1:0] o);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        subject   <= s;
        predicate <= p;
        object_id <= o;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_answers.push_back(apply_triple(op, s, p, o));
    endtask

    // hold the input side until every outstanding answer is back
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        triple_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with nothing pending: hit=%0b full_res=%0b",
                         $time, hit, full_res);
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    mismatch_count++;
                end
                if (full_res !== want.full_res)
                begin
                    $display("%0t: full_res expected %0b actual %0b",
                             $time, want.full_res, full_res);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_triple(OP_ASK, 10'd0, 6'd0, 10'd0);          // empty store
        send_triple(OP_ADD, 10'd0, 6'd0, 10'd0);
        send_triple(OP_ASK, 10'd0, 6'd0, 10'd0);
        send_triple(OP_ADD, 10'd0, 6'd0, 10'd0);          // duplicate add
        send_triple(OP_ASK, 10'd1023, 6'd63, 10'd1023);
        // fill one pair, then overflow it
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd1023);
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd0);
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd512);
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd341);
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd682);    // full pair
        send_triple(OP_ASK, 10'd1023, 6'd63, 10'd682);    // dropped object
        send_triple(OP_ASK, 10'd1023, 6'd63, 10'd341);    // last slot
        send_triple(OP_ADD, 10'd1023, 6'd63, 10'd1023);   // duplicate on a full pair
        send_triple(OP_ASK, 10'd0, 6'd63, 10'd1023);      // subject bit clear
        send_triple(OP_ASK, 10'd1023, 6'd0, 10'd1023);
        send_triple(OP_ASK, 10'd0, 6'd0, 10'd1023);       // bit set, object absent
        send_triple(OP_ADD, 10'd341, 6'd42, 10'd682);
        send_triple(OP_ASK, 10'd341, 6'd42, 10'd682);
        send_triple(OP_ADD, 10'd682, 6'd21, 10'd341);
        send_triple(OP_ASK, 10'd682, 6'd21, 10'd341);
        send_triple(OP_ASK, 10'd682, 6'd21, 10'd682);
        drain_answers();
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned s_pct,
                                       int unsigned r_pct);
        logic [SUBJ_W-1:0] pool_subj [6];
        logic [PRED_W-1:0] pool_pred [6];
        logic [OBJ_W-1:0]  pool_obj  [6];
        logic [SUBJ_W-1:0] s;
        logic [PRED_W-1:0] p;
        logic [OBJ_W-1:0]  o;
        logic              op;
        int unsigned       roll;
        int unsigned       idx;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        // a few hot pairs and objects so pairs fill and duplicates recur
        for (int i = 0; i < 6; i++)
        begin
            pool_subj[i] = SUBJ_W'($urandom_range(0, NUM_SUBJECTS - 1));
            pool_pred[i] = PRED_W'($urandom_range(0, NUM_PREDICATES - 1));
            pool_obj[i]  = OBJ_W'($urandom_range(0, (1 << OBJ_W) - 1));
        end
        for (int unsigned n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, 5);
            s = pool_subj[idx];
            p = pool_pred[idx];
            o = pool_obj[$urandom_range(0, 5)];
            if (roll >= 70 && roll < 85)
                o = OBJ_W'($urandom_range(0, (1 << OBJ_W) - 1));
            else if (roll >= 85)
            begin
                s = SUBJ_W'($urandom_range(0, (1 << SUBJ_W) - 1));
                p = PRED_W'($urandom_range(0, (1 << PRED_W) - 1));
                o = OBJ_W'($urandom_range(0, (1 << OBJ_W) - 1));
            end
            op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_ASK;
            send_triple(op, s, p, o);
            if (n == count / 2)
                drain_answers();
        end
        drain_answers();
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 58;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(300, 17, 58);
        test_random_traffic(300, 58, 17);
        test_random_traffic(300, 0, 0);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
